@@ rtl/core/fscc_pkg.sv @@
// ----------------------------------------------------------------------------
// Flash save command controller package
// Shared types and constants: save types, flash modes, command bytes,
// chip identifiers and the state and action records of the command decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fscc_pkg;

    // Save memory type, as held in the configuration register
    localparam logic [1:0] SAVE_NONE     = 2'd0;
    localparam logic [1:0] SAVE_SRAM     = 2'd1;
    localparam logic [1:0] SAVE_FLASH64  = 2'd2;
    localparam logic [1:0] SAVE_FLASH128 = 2'd3;

    // Access kind
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Flash command state
    typedef enum logic [2:0] {
        MODE_READY = 3'd0,
        MODE_ERASE = 3'd1,
        MODE_ID    = 3'd2,
        MODE_PROG  = 3'd3,
        MODE_BANK  = 3'd4
    } flash_mode_t;

    // Unlock sequence progress
    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_AA   = 2'd1;
    localparam logic [1:0] STEP_55   = 2'd2;

    // Command offsets
    localparam logic [15:0] OFS_UNLOCK1 = 16'h5555;
    localparam logic [15:0] OFS_UNLOCK2 = 16'h2AAA;
    localparam logic [15:0] OFS_BANK    = 16'h0000;

    // Command bytes
    localparam logic [7:0] CMD_UNLOCK1      = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK2      = 8'h55;
    localparam logic [7:0] CMD_ID_ENTER     = 8'h90;
    localparam logic [7:0] CMD_RESET        = 8'hF0;
    localparam logic [7:0] CMD_ERASE_PREP   = 8'h80;
    localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
    localparam logic [7:0] CMD_BANK_SWITCH  = 8'hB0;
    localparam logic [7:0] CMD_CHIP_ERASE   = 8'h10;
    localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;

    // Chip identifiers
    localparam logic [15:0] NO_IDENT    = 16'hFFFF;
    localparam logic [15:0] IDENT_64K   = 16'h1B32;
    localparam logic [15:0] IDENT_128K  = 16'h1362;

    // Erased byte, and the answer of writes and absent save memory
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Flash command state record
    typedef struct packed {
        flash_mode_t mode;
        logic [1:0]  unlock_step;
        logic [15:0] chip_ident;
        logic        active_bank;
    } flash_state_t;

    // Storage work requested by one flash write
    typedef struct packed {
        logic prog_we;
        logic prog_bank;
        logic chip_erase;
        logic sector_erase;
    } cmd_action_t;

endpackage

`default_nettype wire

@@ rtl/core/fscc_cmd.sv @@
// ----------------------------------------------------------------------------
// Flash command decoder
// Decodes one flash write against the current command state: unlock
// sequence, mode commands, byte program, erases and bank switch. Returns
// the next command state and the storage work to perform.
// ----------------------------------------------------------------------------
`default_nettype none

module fscc_cmd #(
    parameter int SECTOR_BYTES = 4096
) (
    input  wire logic [1:0]             save_type,
    input  wire logic [15:0]            address,
    input  wire logic [7:0]             write_data,
    input  wire fscc_pkg::flash_state_t cur_state,
    output fscc_pkg::flash_state_t      next_state,
    output fscc_pkg::cmd_action_t       action
);

    localparam logic [15:0] SECTOR_MASK = 16'(SECTOR_BYTES - 1);

    // Walk the command rules in priority order
    always_comb begin
        fscc_pkg::flash_mode_t mode;
        logic [1:0]            step;
        logic                  done;

        mode       = cur_state.mode;
        step       = cur_state.unlock_step;
        done       = 1'b0;
        next_state = cur_state;
        action     = '0;

        // Bare reset returns to ready regardless of unlock progress
        if (address == fscc_pkg::OFS_UNLOCK1 && write_data == fscc_pkg::CMD_RESET) begin
            mode = fscc_pkg::MODE_READY;
        end

        // Program: store the byte in the active bank
        if (mode == fscc_pkg::MODE_PROG) begin
            action.prog_we   = 1'b1;
            action.prog_bank = cur_state.active_bank;
            mode             = fscc_pkg::MODE_READY;
            step             = fscc_pkg::STEP_IDLE;
            done             = 1'b1;
        end

        if (!done && address == fscc_pkg::OFS_UNLOCK1) begin
            if (write_data == fscc_pkg::CMD_UNLOCK1 && step == fscc_pkg::STEP_IDLE) begin
                step = fscc_pkg::STEP_AA;
            end else begin
                // Take a command after a complete unlock
                if (step == fscc_pkg::STEP_55 &&
                    (mode == fscc_pkg::MODE_ID || mode == fscc_pkg::MODE_READY)) begin
                    unique case (write_data)
                        fscc_pkg::CMD_ID_ENTER: begin
                            mode = fscc_pkg::MODE_ID;
                            if (save_type == fscc_pkg::SAVE_FLASH64) begin
                                next_state.chip_ident = fscc_pkg::IDENT_64K;
                            end else if (save_type == fscc_pkg::SAVE_FLASH128) begin
                                next_state.chip_ident = fscc_pkg::IDENT_128K;
                            end
                        end
                        fscc_pkg::CMD_RESET: begin
                            mode                  = fscc_pkg::MODE_READY;
                            next_state.chip_ident = fscc_pkg::NO_IDENT;
                        end
                        fscc_pkg::CMD_ERASE_PREP:  mode = fscc_pkg::MODE_ERASE;
                        fscc_pkg::CMD_PROGRAM:     mode = fscc_pkg::MODE_PROG;
                        fscc_pkg::CMD_BANK_SWITCH: mode = fscc_pkg::MODE_BANK;
                        default: ;
                    endcase
                    step = fscc_pkg::STEP_IDLE;
                end
                // Chip erase keeps the erase-prepare mode
                if (mode == fscc_pkg::MODE_ERASE && step == fscc_pkg::STEP_55 &&
                    write_data == fscc_pkg::CMD_CHIP_ERASE) begin
                    action.chip_erase = 1'b1;
                    step              = fscc_pkg::STEP_IDLE;
                end
            end
        end else if (!done && address == fscc_pkg::OFS_UNLOCK2) begin
            if (step == fscc_pkg::STEP_AA && write_data == fscc_pkg::CMD_UNLOCK2) begin
                step = fscc_pkg::STEP_55;
            end
        end else if (!done && (address & SECTOR_MASK) == 16'd0 &&
                     mode == fscc_pkg::MODE_ERASE && step == fscc_pkg::STEP_55) begin
            if (write_data == fscc_pkg::CMD_SECTOR_ERASE) begin
                action.sector_erase = 1'b1;
                mode                = fscc_pkg::MODE_READY;
                step                = fscc_pkg::STEP_IDLE;
            end
        end else if (!done && address == fscc_pkg::OFS_BANK &&
                     mode == fscc_pkg::MODE_BANK) begin
            if (save_type == fscc_pkg::SAVE_FLASH128) begin
                next_state.active_bank = write_data[0];
            end
            mode = fscc_pkg::MODE_READY;
            step = fscc_pkg::STEP_IDLE;
        end

        next_state.mode        = mode;
        next_state.unlock_step = step;
    end

endmodule

`default_nettype wire

@@ rtl/core/flash_save_command_controller_top.sv @@
// ----------------------------------------------------------------------------
// Flash save command controller
// Byte-wide save memory behind a valid/ready channel: none, SRAM, or
// command-driven flash in one or two banks held in two RAMs.
// ----------------------------------------------------------------------------
// Path: a write answer passes the result buffer and the output register; a read
//   first waits in ST_READ for the registered RAM read ahead of the result buffer.
// Flow: a new transaction is taken only once the result buffer has drained, so an
//   access is not taken before the last one is through; sector erase holds input while
//   one sector is filled and chip erase while a whole bank is, one RAM entry per cycle.
// Reset: a clearing pass fills both banks with 0xFF.
`default_nettype none

module flash_save_command_controller_top #(
    parameter int BANK_BYTES   = 65536,
    parameter int SECTOR_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    // access requests
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [15:0] s_address,
    input  wire logic [7:0]  s_write_data,
    // read results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data
);

    localparam int AW        = $clog2(BANK_BYTES);
    localparam int SPAN      = (SECTOR_BYTES < BANK_BYTES) ? SECTOR_BYTES : BANK_BYTES;
    localparam logic [AW-1:0] BANK_MASK = AW'(BANK_BYTES - 1);
    localparam logic [AW-1:0] SPAN_MASK = AW'(SPAN - 1);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ
    } state_t;

    // Control state
    state_t                 state_reg, state_next;
    logic [1:0]             save_type_reg, save_type_next;
    fscc_pkg::flash_state_t flash_reg, flash_next;
    logic [AW-1:0]          sweep_addr_reg, sweep_addr_next;
    logic                   sweep_full_reg, sweep_full_next;
    logic                   sweep_both_reg, sweep_both_next;
    logic                   sweep_bank_reg, sweep_bank_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   m_valid_reg, m_valid_next;

    // Payload
    logic [7:0]             pend_data_reg, pend_data_next;
    logic [7:0]             m_read_data_reg, m_read_data_next;
    logic                   rd_bank_reg, rd_bank_next;
    logic                   rd_fixed_reg, rd_fixed_next;
    logic [7:0]             rd_fixed_data_reg, rd_fixed_data_next;

    // Storage
    logic [7:0]             bank0_mem [BANK_BYTES];
    logic [7:0]             bank1_mem [BANK_BYTES];
    logic [7:0]             rd_data0_reg, rd_data1_reg;

    fscc_pkg::flash_state_t cmd_next;
    fscc_pkg::cmd_action_t  cmd_act;

    logic                   accept;
    logic                   is_flash;
    logic                   flash_write;
    logic                   out_load;
    logic                   sweep_last;
    logic [AW-1:0]          item_idx;
    logic                   item_we0, item_we1;
    logic                   we0, we1;
    logic [AW-1:0]          wr_addr;
    logic [7:0]             wr_data;
    logic [7:0]             read_byte;

    fscc_cmd #(
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_cmd (
        .save_type (save_type_reg),
        .address   (s_address),
        .write_data(s_write_data),
        .cur_state (flash_reg),
        .next_state(cmd_next),
        .action    (cmd_act)
    );

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;

    assign accept      = s_valid && s_ready;
    assign is_flash    = (save_type_reg == fscc_pkg::SAVE_FLASH64) ||
                         (save_type_reg == fscc_pkg::SAVE_FLASH128);
    assign flash_write = accept && is_flash && (s_func == fscc_pkg::FUNC_WRITE);
    assign out_load    = pend_valid_reg && (!m_valid_reg || m_ready);
    assign sweep_last  = (sweep_addr_reg & (sweep_full_reg ? BANK_MASK : SPAN_MASK)) ==
                         (sweep_full_reg ? BANK_MASK : SPAN_MASK);
    assign item_idx    = s_address[AW-1:0];

    // Route item writes: SRAM to bank 0, program to the active bank
    always_comb begin
        item_we0 = 1'b0;
        item_we1 = 1'b0;
        if (accept && s_func == fscc_pkg::FUNC_WRITE) begin
            if (save_type_reg == fscc_pkg::SAVE_SRAM) begin
                item_we0 = 1'b1;
            end else if (flash_write && cmd_act.prog_we) begin
                item_we0 = !cmd_act.prog_bank;
                item_we1 = cmd_act.prog_bank;
            end
        end
    end

    // Mux sweep fills and item writes onto the write port
    always_comb begin
        if (state_reg == ST_SWEEP) begin
            we0     = sweep_both_reg || !sweep_bank_reg;
            we1     = sweep_both_reg || sweep_bank_reg;
            wr_addr = sweep_addr_reg;
            wr_data = fscc_pkg::ERASED_BYTE;
        end else begin
            we0     = item_we0;
            we1     = item_we1;
            wr_addr = item_idx;
            wr_data = s_write_data;
        end
    end

    // Bank RAMs: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we0) begin
            bank0_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            rd_data0_reg <= bank0_mem[item_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (we1) begin
            bank1_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            rd_data1_reg <= bank1_mem[item_idx];
        end
    end

    assign read_byte = rd_fixed_reg ? rd_fixed_data_reg :
                       (rd_bank_reg ? rd_data1_reg : rd_data0_reg);

    // Next-state logic
    always_comb begin
        state_next         = state_reg;
        save_type_next     = save_type_reg;
        flash_next         = flash_reg;
        sweep_addr_next    = sweep_addr_reg;
        sweep_full_next    = sweep_full_reg;
        sweep_both_next    = sweep_both_reg;
        sweep_bank_next    = sweep_bank_reg;
        pend_valid_next    = pend_valid_reg;
        pend_data_next     = pend_data_reg;
        m_valid_next       = m_valid_reg;
        m_read_data_next   = m_read_data_reg;
        rd_bank_next       = rd_bank_reg;
        rd_fixed_next      = rd_fixed_reg;
        rd_fixed_data_next = rd_fixed_data_reg;

        if (cfg_valid && cfg_ready) begin
            save_type_next = cfg_data;
        end

        // Drain the result buffer into the output register
        if (out_load) begin
            m_valid_next     = 1'b1;
            m_read_data_next = pend_data_reg;
            pend_valid_next  = 1'b0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP: begin
                sweep_addr_next = sweep_addr_reg + AW'(1);
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_func == fscc_pkg::FUNC_READ &&
                        save_type_reg != fscc_pkg::SAVE_NONE) begin
                        // Read: wait in ST_READ for RAM data
                        state_next         = ST_READ;
                        rd_bank_next       = is_flash && flash_reg.active_bank;
                        rd_fixed_next      = is_flash &&
                                             flash_reg.chip_ident != fscc_pkg::NO_IDENT &&
                                             s_address <= 16'd1;
                        rd_fixed_data_next = s_address[0] ? flash_reg.chip_ident[15:8]
                                                          : flash_reg.chip_ident[7:0];
                    end else begin
                        pend_valid_next = 1'b1;
                        pend_data_next  = fscc_pkg::ERASED_BYTE;
                    end
                    if (flash_write) begin
                        flash_next = cmd_next;
                        if (cmd_act.chip_erase) begin
                            state_next      = ST_SWEEP;
                            sweep_addr_next = '0;
                            sweep_full_next = 1'b1;
                            sweep_both_next = 1'b1;
                        end else if (cmd_act.sector_erase) begin
                            state_next      = ST_SWEEP;
                            sweep_addr_next = item_idx;
                            sweep_full_next = 1'b0;
                            sweep_both_next = 1'b0;
                            sweep_bank_next = flash_reg.active_bank;
                        end
                    end
                end
            end
            ST_READ: begin
                pend_valid_next = 1'b1;
                pend_data_next  = read_byte;
                state_next      = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            save_type_reg  <= fscc_pkg::SAVE_NONE;
            flash_reg      <= '{mode: fscc_pkg::MODE_READY,
                                unlock_step: fscc_pkg::STEP_IDLE,
                                chip_ident: fscc_pkg::NO_IDENT,
                                active_bank: 1'b0};
            sweep_addr_reg <= '0;
            sweep_full_reg <= 1'b1;
            sweep_both_reg <= 1'b1;
            sweep_bank_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            save_type_reg  <= save_type_next;
            flash_reg      <= flash_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_full_reg <= sweep_full_next;
            sweep_both_reg <= sweep_both_next;
            sweep_bank_reg <= sweep_bank_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_data_reg     <= pend_data_next;
        m_read_data_reg   <= m_read_data_next;
        rd_bank_reg       <= rd_bank_next;
        rd_fixed_reg      <= rd_fixed_next;
        rd_fixed_data_reg <= rd_fixed_data_next;
    end

`ifndef NO_ASSERTIONS
    // An accepted transaction has a result buffered or a read in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (pend_valid_reg || state_reg == ST_READ))
        else $error("accepted transaction produced no pending work");

    // Item writes never collide with a fill sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        !((item_we0 || item_we1) && state_reg == ST_SWEEP))
        else $error("item write during fill sweep");

    // RAM read data is consumed in the cycle after issue
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> state_reg != ST_READ)
        else $error("read wait longer than one cycle");

    // Unlock progress never passes the second unlock byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        flash_reg.unlock_step != 2'd3)
        else $error("unlock step out of range");

    // Chip ident holds one of the known identifiers or none
    assert property (@(posedge aclk) disable iff (!aresetn)
        flash_reg.chip_ident == fscc_pkg::NO_IDENT ||
        flash_reg.chip_ident == fscc_pkg::IDENT_64K ||
        flash_reg.chip_ident == fscc_pkg::IDENT_128K)
        else $error("chip ident corrupted");
`endif

endmodule

`default_nettype wire

@@ sim/tb_flash_save_command_controller_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flash save command controller testbench
// Drives byte accesses through the request channel. A built-in model of the
// save memory and the flash command decoder predicts every read byte. The
// model covers the none, SRAM and flash save types, unlock sequences,
// ID mode, program, bank switch, sector erase and chip erase. Each returned
// byte is checked in order. Phases change the save type while the block is
// idle and vary sender gaps and receiver stalls, including a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_flash_save_command_controller_top;
    import fscc_pkg::*;

    localparam int BANK_SIZE       = 65536;
    localparam int SECTOR_SIZE     = 4096;
    localparam int WATCHDOG_CYCLES = 200000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct {
        logic        func;
        logic [15:0] address;
        logic [7:0]  wdata;
    } access_t;

    typedef enum {
        PACE_FULL,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH,
        PACE_BACKPRESSURE
    } pace_t;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data     = 2'd0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic        s_func       = 1'b0;
    logic [15:0] s_address    = 16'h0000;
    logic [7:0]  s_write_data = 8'h00;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_read_data;

    // Pending accesses and the read bytes they are owed
    access_t     access_q[$];
    access_t     next_access;
    logic [7:0]  predicted_reads[$];
    logic [7:0]  owed_byte;

    // Predicted save memory and command decoder state
    logic [7:0]  mem_bank0 [BANK_SIZE];
    logic [7:0]  mem_bank1 [BANK_SIZE];
    flash_mode_t pred_mode;
    logic [1:0]  pred_step;
    logic [15:0] pred_ident;
    logic        pred_bank;
    logic [1:0]  pred_save_type;

    int sender_idle_pct  = 0;
    int recv_stall_pct   = 0;
    int hold_serial      = 0;
    int hold_served      = 0;
    int hold_left        = 0;
    int errors           = 0;
    int idle_cycles      = 0;
    int queued_total     = 0;
    int sector_erases_left = 14;
    int chip_erases_left   = 3;

    flash_save_command_controller_top #(
        .BANK_BYTES   (BANK_SIZE),
        .SECTOR_BYTES (SECTOR_SIZE)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Apply one flash write to the predicted decoder and stores
    function automatic void flash_command(input logic [15:0] a, input logic [7:0] v);
        // bare reset always drops back to ready
        if (a == OFS_UNLOCK1 && v == CMD_RESET)
            pred_mode = MODE_READY;

        if (pred_mode == MODE_PROG) begin
            if (pred_bank)
                mem_bank1[a] = v;
            else
                mem_bank0[a] = v;
            pred_mode = MODE_READY;
            pred_step = STEP_IDLE;
            return;
        end

        if (a == OFS_UNLOCK1) begin
            if (v == CMD_UNLOCK1 && pred_step == STEP_IDLE) begin
                pred_step = STEP_AA;
                return;
            end
            if (pred_step == STEP_55 && (pred_mode == MODE_ID || pred_mode == MODE_READY)) begin
                case (v)
                    CMD_ID_ENTER: begin
                        pred_mode = MODE_ID;
                        if (pred_save_type == SAVE_FLASH64)
                            pred_ident = IDENT_64K;
                        else if (pred_save_type == SAVE_FLASH128)
                            pred_ident = IDENT_128K;
                    end
                    CMD_RESET: begin
                        pred_mode  = MODE_READY;
                        pred_ident = NO_IDENT;
                    end
                    CMD_ERASE_PREP:  pred_mode = MODE_ERASE;
                    CMD_PROGRAM:     pred_mode = MODE_PROG;
                    CMD_BANK_SWITCH: pred_mode = MODE_BANK;
                    default: ;
                endcase
                pred_step = STEP_IDLE;
            end
            // chip erase wipes both banks and stays in erase prepare
            if (pred_mode == MODE_ERASE && pred_step == STEP_55 && v == CMD_CHIP_ERASE) begin
                for (int i = 0; i < BANK_SIZE; i++) begin
                    mem_bank0[i] = ERASED_BYTE;
                    mem_bank1[i] = ERASED_BYTE;
                end
                pred_step = STEP_IDLE;
            end
        end else if (a == OFS_UNLOCK2) begin
            if (pred_step == STEP_AA && v == CMD_UNLOCK2)
                pred_step = STEP_55;
        end else if ((a & 16'(SECTOR_SIZE - 1)) == 16'h0000 && pred_mode == MODE_ERASE
                     && pred_step == STEP_55) begin
            if (v == CMD_SECTOR_ERASE) begin
                // clip the fill at the end of the bank
                for (int i = 0; i < SECTOR_SIZE && int'(a) + i < BANK_SIZE; i++) begin
                    if (pred_bank)
                        mem_bank1[int'(a) + i] = ERASED_BYTE;
                    else
                        mem_bank0[int'(a) + i] = ERASED_BYTE;
                end
                pred_step = STEP_IDLE;
                pred_mode = MODE_READY;
            end
        end else if (a == OFS_BANK && pred_mode == MODE_BANK) begin
            if (pred_save_type == SAVE_FLASH128)
                pred_bank = v[0];
            pred_mode = MODE_READY;
            pred_step = STEP_IDLE;
        end
    endfunction

    // Work out the byte returned for one access and update the state
    function automatic logic [7:0] predict_access(input logic f, input logic [15:0] a,
                                                  input logic [7:0] v);
        logic [7:0] r;
        r = ERASED_BYTE;
        case (pred_save_type)
            SAVE_SRAM: begin
                if (f == FUNC_WRITE)
                    mem_bank0[a] = v;
                else
                    r = mem_bank0[a];
            end
            SAVE_FLASH64, SAVE_FLASH128: begin
                if (f == FUNC_WRITE)
                    flash_command(a, v);
                else if (pred_ident != NO_IDENT && a <= 16'd1)
                    r = a[0] ? pred_ident[15:8] : pred_ident[7:0];
                else
                    r = pred_bank ? mem_bank1[a] : mem_bank0[a];
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Queue one access; erase command bytes only where asked for
    function automatic void queue_access(input logic f, input logic [15:0] a,
                                         input logic [7:0] d, input bit erase_ok = 1'b0);
        access_t    acc;
        logic [7:0] dv;
        dv = d;
        if (f == FUNC_WRITE && !erase_ok && (dv == CMD_CHIP_ERASE || dv == CMD_SECTOR_ERASE))
            dv[0] = ~dv[0];
        acc.func    = f;
        acc.address = a;
        acc.wdata   = dv;
        access_q.push_back(acc);
        queued_total++;
    endfunction

    function automatic void queue_unlock();
        queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_UNLOCK1);
        queue_access(FUNC_WRITE, OFS_UNLOCK2, CMD_UNLOCK2);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Mix of wide offsets, a small window that gets revisited, and edges
    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: begin
                case ($urandom_range(0, 4))
                    0: return 16'h0000;
                    1: return 16'h0001;
                    2: return 16'hFFFF;
                    3: return OFS_UNLOCK1;
                    default: return OFS_UNLOCK2;
                endcase
            end
            default: return 16'h0100 + 16'($urandom_range(0, 31));
        endcase
    endfunction

    // One flash command sequence, mostly well formed with random content
    function automatic void add_flash_sequence();
        int          pick;
        logic [15:0] a;
        logic [15:0] sector;
        pick = $urandom_range(0, 99);
        a    = pick_address();
        if (pick < 12) begin
            queue_access(FUNC_READ, a, rand_byte());
        end else if (pick < 20) begin
            queue_access(FUNC_READ, 16'($urandom_range(0, 1)), rand_byte());
        end else if (pick < 30) begin
            queue_unlock();
            queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_ID_ENTER);
            queue_access(FUNC_READ, 16'($urandom_range(0, 1)), rand_byte());
        end else if (pick < 38) begin
            queue_unlock();
            queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_RESET);
            queue_access(FUNC_READ, a, rand_byte());
        end else if (pick < 52) begin
            queue_unlock();
            queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_PROGRAM);
            queue_access(FUNC_WRITE, a, rand_byte());
            queue_access(FUNC_READ, a, rand_byte());
        end else if (pick < 60) begin
            queue_unlock();
            queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_BANK_SWITCH);
            queue_access(FUNC_WRITE, OFS_BANK, rand_byte());
            queue_access(FUNC_READ, a, rand_byte());
        end else if (pick < 70) begin
            // sector erase, limited since each one holds the block for a sector
            queue_unlock();
            queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_ERASE_PREP);
            queue_unlock();
            if (sector_erases_left > 0) begin
                sector_erases_left--;
                sector = 16'($urandom_range(0, 15)) << 12;
                queue_access(FUNC_WRITE, sector, CMD_SECTOR_ERASE, 1'b1);
                queue_access(FUNC_READ, sector | 16'($urandom_range(0, SECTOR_SIZE - 1)),
                             rand_byte());
            end else begin
                queue_access(FUNC_WRITE, a, rand_byte());
            end
        end else if (pick < 75) begin
            // chip erase, limited since each one holds the block for a whole bank
            queue_unlock();
            queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_ERASE_PREP);
            queue_unlock();
            if (chip_erases_left > 0) begin
                chip_erases_left--;
                queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_CHIP_ERASE, 1'b1);
                queue_access(FUNC_READ, a, rand_byte());
            end else begin
                queue_access(FUNC_WRITE, OFS_UNLOCK1, rand_byte());
            end
        end else if (pick < 82) begin
            queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_RESET);
        end else if (pick < 92) begin
            // broken unlock sequences
            case ($urandom_range(0, 2))
                0: begin
                    queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_UNLOCK1);
                    queue_access(FUNC_WRITE, a, rand_byte());
                end
                1: begin
                    queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_UNLOCK1);
                    queue_access(FUNC_WRITE, a, CMD_UNLOCK2);
                    queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_ID_ENTER);
                end
                default: begin
                    queue_unlock();
                    queue_access(FUNC_WRITE, OFS_UNLOCK1, rand_byte());
                end
            endcase
        end else begin
            queue_access(FUNC_WRITE, a, rand_byte());
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: predicts each accepted transaction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            for (int i = 0; i < BANK_SIZE; i++) begin
                mem_bank0[i] = ERASED_BYTE;
                mem_bank1[i] = ERASED_BYTE;
            end
            pred_mode      = MODE_READY;
            pred_step      = STEP_IDLE;
            pred_ident     = NO_IDENT;
            pred_bank      = 1'b0;
            pred_save_type = SAVE_NONE;
        end else begin
            if (cfg_valid && cfg_ready)
                pred_save_type = cfg_data;
            if (s_valid && s_ready)
                predicted_reads.push_back(predict_access(s_func, s_address, s_write_data));
            // hold the payload until accepted, then offer the next or idle
            if (!s_valid || s_ready) begin
                if (access_q.size() != 0
                    && int'($urandom_range(0, 99)) >= sender_idle_pct) begin
                    next_access = access_q.pop_front();
                    s_valid      <= 1'b1;
                    s_func       <= next_access.func;
                    s_address    <= next_access.address;
                    s_write_data <= next_access.wdata;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls and the long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_served != hold_serial) begin
            hold_served <= hold_serial;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= int'($urandom_range(0, 99)) >= recv_stall_pct;
        end
    end

    // Check each returned byte against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (predicted_reads.size() == 0) begin
                $error("read_data: no transaction outstanding, actual %02h", m_read_data);
                errors++;
            end else begin
                owed_byte = predicted_reads.pop_front();
                if (m_read_data !== owed_byte) begin
                    $error("read_data mismatch: expected %02h, actual %02h",
                           owed_byte, m_read_data);
                    errors++;
                end
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("FAIL flash_save_command_controller_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------

    // Wait until every access is accepted and answered, then let it settle
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (access_q.size() != 0 || s_valid || predicted_reads.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_save_type(input logic [1:0] t);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= t;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [1:0] phase_type;
        pace_t      phase_pace;
        int         phase_len;
        int         start_count;

        wait (aresetn);

        // no save memory: writes and reads all answer erased
        write_save_type(SAVE_NONE);
        @(negedge aclk);
        queue_access(FUNC_WRITE, 16'hFFFF, 8'h00);
        queue_access(FUNC_READ, 16'h0000, 8'hFF);
        wait_drained();

        // SRAM at both ends of the offset range
        write_save_type(SAVE_SRAM);
        @(negedge aclk);
        queue_access(FUNC_WRITE, 16'hFFFF, 8'h00);
        queue_access(FUNC_WRITE, 16'h0000, 8'hFF);
        queue_access(FUNC_READ, 16'hFFFF, 8'h00);
        wait_drained();

        // two-bank flash: ID mode, bare reset keeps the ID, exit, bank switch
        write_save_type(SAVE_FLASH128);
        @(negedge aclk);
        queue_unlock();
        queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_ID_ENTER);
        queue_access(FUNC_READ, 16'h0000, 8'h00);
        queue_access(FUNC_READ, 16'h0001, 8'h00);
        queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_RESET);
        queue_access(FUNC_READ, 16'h0001, 8'h00);
        queue_unlock();
        queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_RESET);
        queue_access(FUNC_READ, 16'h0000, 8'h00);
        queue_unlock();
        queue_access(FUNC_WRITE, OFS_UNLOCK1, CMD_BANK_SWITCH);
        queue_access(FUNC_WRITE, OFS_BANK, 8'hFF);

        // random phases over save types and pacing
        for (int k = 0; k < 10; k++) begin
            case (k)
                0: begin phase_type = SAVE_FLASH64;  phase_pace = PACE_FULL;         phase_len = 50; end
                1: begin phase_type = SAVE_FLASH128; phase_pace = PACE_SEND_GAPS;    phase_len = 50; end
                2: begin phase_type = SAVE_SRAM;     phase_pace = PACE_RECV_STALLS;  phase_len = 40; end
                3: begin phase_type = SAVE_FLASH128; phase_pace = PACE_BOTH;         phase_len = 60; end
                4: begin phase_type = SAVE_FLASH64;  phase_pace = PACE_BACKPRESSURE; phase_len = 50; end
                5: begin phase_type = SAVE_NONE;     phase_pace = PACE_FULL;         phase_len = 15; end
                6: begin phase_type = SAVE_FLASH128; phase_pace = PACE_RECV_STALLS;  phase_len = 50; end
                7: begin phase_type = SAVE_FLASH64;  phase_pace = PACE_BOTH;         phase_len = 45; end
                8: begin phase_type = SAVE_SRAM;     phase_pace = PACE_SEND_GAPS;    phase_len = 20; end
                default: begin
                    phase_type = SAVE_FLASH128; phase_pace = PACE_FULL; phase_len = 30;
                end
            endcase

            wait_drained();
            write_save_type(phase_type);
            @(negedge aclk);
            case (phase_pace)
                PACE_SEND_GAPS:   begin sender_idle_pct = 70; recv_stall_pct = 0;  end
                PACE_RECV_STALLS: begin sender_idle_pct = 0;  recv_stall_pct = 70; end
                PACE_BOTH:        begin sender_idle_pct = 14; recv_stall_pct = 14; end
                default:          begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase

            start_count = queued_total;
            while (queued_total - start_count < phase_len) begin
                case (phase_type)
                    SAVE_FLASH64, SAVE_FLASH128: add_flash_sequence();
                    SAVE_SRAM: begin
                        if ($urandom_range(0, 1) == 0)
                            queue_access(FUNC_WRITE, pick_address(), rand_byte());
                        else
                            queue_access(FUNC_READ, pick_address(), rand_byte());
                    end
                    default: queue_access(1'($urandom_range(0, 1)),
                                          16'($urandom_range(0, 65535)), rand_byte());
                endcase
            end

            // stop taking results while the sender keeps offering
            if (phase_pace == PACE_BACKPRESSURE)
                hold_serial++;
        end

        wait_drained();
        if (errors == 0)
            $display("PASS flash_save_command_controller_top");
        else
            $display("FAIL flash_save_command_controller_top");
        $finish;
    end

endmodule
